/* sv/wdc_pkg.sv */
// shared types, constants and calendar helpers for the workday counter
package wdc_pkg;

  // field widths
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned COUNT_W    = 22;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // default upper year bound
  localparam int unsigned YEAR_MAX_DEF = 9999;

  // saturation value of the count
  localparam int unsigned COUNT_MAX = 4194303;

  // quotient width of a 14-bit year divided by 100
  localparam int unsigned CENT_W = 8;

  // divisor width of the shared divider
  localparam int unsigned DVS_W = 7;

  localparam logic [DVS_W-1:0] DVS_CENTURY = 7'd100;
  localparam logic [DVS_W-1:0] DVS_WEEK    = 7'd7;

  // weekday codes, 0 is sunday
  localparam logic [2:0] FRIDAY   = 3'd5;
  localparam logic [2:0] SATURDAY = 3'd6;

  // weekday of serial day number s is (s + WDAY_SHIFT) mod 7
  localparam logic [2:0] WDAY_SHIFT = 3'd2;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // one input beat, start_day in the lowest bits, include_end in the highest
  typedef struct packed {
    logic               include_end;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
  } item_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_YS,
    ST_DIV_YE,
    ST_CHECK,
    ST_SUM_S,
    ST_BASE_E,
    ST_SUM_E,
    ST_DIFF,
    ST_DIV_N,
    ST_DIV_WDAY,
    ST_TALLY,
    ST_FINISH
  } state_e;

  // days before the month in a year that starts in march
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    unique case (m)
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // length of a month, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // workdays among the r days that begin with a day on weekday w
  function automatic logic [2:0] tail_days(input logic [2:0] w, input logic [2:0] r);
    logic [2:0] n;
    logic [3:0] wd;
    n = 3'd0;
    for (int i = 0; i < 6; i++) begin
      wd = 4'(w) + 4'(i);
      if (wd >= 4'd7) begin
        wd = wd - 4'd7;
      end
      if ((3'(i) < r) && (wd[2:0] != FRIDAY) && (wd[2:0] != SATURDAY)) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

/* sv/workday_count_between_dates.sv */
// Workday counter between two Gregorian dates. A start and an end date arrive in one input beat;
// the result beat carries the number of days from the start up to but not including the end whose
// weekday is neither Friday nor Saturday, plus one when include_end is set (0 or 1 when the end is
// not after the start), and flags a date with a bad month, a zero or too large day, or a year
// outside 1..YEAR_MAX, with a count of 0. A single shared divider by a constant (a multiply by the
// reciprocal, then a multiply back for the remainder) does all the division: the two years by 100,
// the span by 7 and the start day number by 7. A valid pair with the end after the start passes
// all the states; an end not after the start skips the span and weekday divisions, and an
// invalid date skips the day numbers as well. The result sits in an output register, so the next
// item is accepted while it waits; a second finished result holds the block until the first beat
// has been taken.
module workday_count_between_dates #(
  parameter int unsigned YEAR_MAX = wdc_pkg::YEAR_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, include_end
  input  logic [wdc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // workday_count
  output logic [wdc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // date_invalid
  output logic [0:0]                       m_axis_tuser
);

  localparam int unsigned SER_W  = $clog2(366 * (YEAR_MAX + 1));
  localparam int unsigned DIV_W  = (SER_W > wdc_pkg::YEAR_W) ? SER_W : wdc_pkg::YEAR_W;
  localparam int unsigned SUM_W  = SER_W + 3;
  localparam int unsigned ITEM_W = $bits(wdc_pkg::item_t);

  // reciprocal scaling: seven guard bits keep the error below 1/128 of a unit
  localparam int unsigned RCP_GUARD = 7;
  localparam int unsigned RCP_SH    = DIV_W + RCP_GUARD;
  localparam int unsigned RCP_W     = DIV_W + 5;
  localparam int unsigned PROD_W    = DIV_W + RCP_SH;
  localparam logic [RCP_W-1:0] RCP_CENT =
    RCP_W'(((64'd1 << RCP_SH) + 64'(wdc_pkg::DVS_CENTURY) - 64'd1) /
           64'(wdc_pkg::DVS_CENTURY));
  localparam logic [RCP_W-1:0] RCP_WEEK =
    RCP_W'(((64'd1 << RCP_SH) + 64'(wdc_pkg::DVS_WEEK) - 64'd1) / 64'(wdc_pkg::DVS_WEEK));

  wdc_pkg::state_e state_q, state_d;
  wdc_pkg::item_t  item_q, s_item;

  logic s_hs;
  logic out_load;

  // shared divider
  logic [DIV_W-1:0]          div_num_q;
  logic [wdc_pkg::DVS_W-1:0] div_dvs_q;
  logic [DIV_W-1:0]          div_quo_q;
  logic                      div_half_q;
  logic                      div_done;
  logic [RCP_W-1:0]          rcp_sel;
  logic [PROD_W-1:0]         div_prod;
  logic [DIV_W-1:0]          div_quo_d;
  logic [wdc_pkg::DVS_W-1:0] div_back;
  logic [wdc_pkg::DVS_W-1:0] div_rem;
  logic                      div_ld;
  logic [DIV_W-1:0]          div_ld_num;
  logic [wdc_pkg::DVS_W-1:0] div_ld_dvs;

  // per-date results of the year division
  logic [wdc_pkg::CENT_W-1:0] cs_q, ce_q;
  logic [wdc_pkg::DVS_W-1:0]  rs_q, re_q;

  // day number datapath
  logic                        sel_end;
  logic [wdc_pkg::DAY_W-1:0]   d_sel;
  logic [wdc_pkg::MONTH_W-1:0] m_sel;
  logic [wdc_pkg::YEAR_W-1:0]  y_sel;
  logic [wdc_pkg::CENT_W-1:0]  c_sel;
  logic [wdc_pkg::DVS_W-1:0]   r_sel;
  logic                        early;
  logic [wdc_pkg::YEAR_W-1:0]  yy_sel;
  logic [wdc_pkg::CENT_W-1:0]  cyy_sel;
  logic [SER_W-1:0]            base_val;
  logic [SER_W-1:0]            term_val;
  logic [SER_W-1:0]            base_q;
  logic [SER_W-1:0]            ser_s_q, ser_e_q;

  // validity
  logic leap_s, leap_e, ok_s, ok_e, dates_ok;

  // tally
  logic [SER_W-1:0]           quo_q;
  logic [2:0]                 rmd_q;
  logic [2:0]                 wday_q;
  logic [3:0]                 wday_raw;
  logic [2:0]                 wday_nxt;
  logic [SUM_W-1:0]           tally_wide;
  logic [wdc_pkg::COUNT_W-1:0] tally_cnt;

  // result and output registers
  logic [wdc_pkg::COUNT_W-1:0] res_cnt_q, out_cnt_q;
  logic                        res_inv_q, out_inv_q;
  logic                        out_valid_q;

  assign s_item = wdc_pkg::item_t'(s_axis_tdata[ITEM_W-1:0]);
  assign s_hs   = s_axis_tvalid && s_axis_tready;

  // quotient by reciprocal multiply, remainder by multiply back in the low bits
  assign rcp_sel   = (div_dvs_q == wdc_pkg::DVS_WEEK) ? RCP_WEEK : RCP_CENT;
  assign div_prod  = PROD_W'(div_num_q) * PROD_W'(rcp_sel);
  assign div_quo_d = div_prod[RCP_SH +: DIV_W];
  assign div_back  = div_quo_q[wdc_pkg::DVS_W-1:0] * div_dvs_q;
  assign div_rem   = div_num_q[wdc_pkg::DVS_W-1:0] - div_back;
  assign div_done  = div_half_q;

  // leap year from year mod 100 and year div 100
  assign leap_s = ((item_q.start_year[1:0] == 2'd0) && (rs_q != '0)) ||
                  ((rs_q == '0) && (cs_q[1:0] == 2'd0));
  assign leap_e = ((item_q.end_year[1:0] == 2'd0) && (re_q != '0)) ||
                  ((re_q == '0) && (ce_q[1:0] == 2'd0));

  // calendar checks on both dates
  assign ok_s = (item_q.start_year != '0) && (32'(item_q.start_year) <= YEAR_MAX) &&
                (item_q.start_month >= wdc_pkg::MONTH_JAN) &&
                (item_q.start_month <= wdc_pkg::MONTH_DEC) &&
                (item_q.start_day != '0) &&
                (item_q.start_day <= wdc_pkg::month_len(item_q.start_month, leap_s));
  assign ok_e = (item_q.end_year != '0) && (32'(item_q.end_year) <= YEAR_MAX) &&
                (item_q.end_month >= wdc_pkg::MONTH_JAN) &&
                (item_q.end_month <= wdc_pkg::MONTH_DEC) &&
                (item_q.end_day != '0) &&
                (item_q.end_day <= wdc_pkg::month_len(item_q.end_month, leap_e));
  assign dates_ok = ok_s && ok_e;

  // date select for the shared day number unit
  assign sel_end = (state_q == wdc_pkg::ST_BASE_E) || (state_q == wdc_pkg::ST_SUM_E);
  assign d_sel   = sel_end ? item_q.end_day   : item_q.start_day;
  assign m_sel   = sel_end ? item_q.end_month : item_q.start_month;
  assign y_sel   = sel_end ? item_q.end_year  : item_q.start_year;
  assign c_sel   = sel_end ? ce_q : cs_q;
  assign r_sel   = sel_end ? re_q : rs_q;

  // january and february count to the previous year
  assign early   = m_sel <= wdc_pkg::MONTH_FEB;
  assign yy_sel  = y_sel - wdc_pkg::YEAR_W'(early);
  assign cyy_sel = c_sel - wdc_pkg::CENT_W'(early && (r_sel == '0));

  // day number in two passes: days of whole years, months and days, then leap corrections
  assign base_val = SER_W'(yy_sel) * SER_W'(wdc_pkg::DAYS_PER_YEAR) + SER_W'(d_sel) +
                    SER_W'(wdc_pkg::month_offset(m_sel));
  assign term_val = base_q + SER_W'(yy_sel >> 2) - SER_W'(cyy_sel) + SER_W'(cyy_sel >> 2);

  // weekday of the start from its day number mod 7
  assign wday_raw = 4'(div_rem[2:0]) + 4'(wdc_pkg::WDAY_SHIFT);
  assign wday_nxt = (wday_raw >= 4'd7) ? 3'(wday_raw - 4'd7) : wday_raw[2:0];

  // five workdays per full week, the rest by table, plus include_end, then saturate
  assign tally_wide = (SUM_W'(quo_q) << 2) + SUM_W'(quo_q) +
                      SUM_W'(wdc_pkg::tail_days(wday_q, rmd_q)) + SUM_W'(item_q.include_end);
  assign tally_cnt  = (32'(tally_wide) > wdc_pkg::COUNT_MAX) ?
                      wdc_pkg::COUNT_W'(wdc_pkg::COUNT_MAX) : wdc_pkg::COUNT_W'(tally_wide);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wdc_pkg::ST_IDLE: begin
        if (s_hs) state_d = wdc_pkg::ST_DIV_YS;
      end
      wdc_pkg::ST_DIV_YS: begin
        if (div_done) state_d = wdc_pkg::ST_DIV_YE;
      end
      wdc_pkg::ST_DIV_YE: begin
        if (div_done) state_d = wdc_pkg::ST_CHECK;
      end
      wdc_pkg::ST_CHECK: begin
        state_d = dates_ok ? wdc_pkg::ST_SUM_S : wdc_pkg::ST_FINISH;
      end
      wdc_pkg::ST_SUM_S:  state_d = wdc_pkg::ST_BASE_E;
      wdc_pkg::ST_BASE_E: state_d = wdc_pkg::ST_SUM_E;
      wdc_pkg::ST_SUM_E:  state_d = wdc_pkg::ST_DIFF;
      wdc_pkg::ST_DIFF: begin
        state_d = (ser_e_q > ser_s_q) ? wdc_pkg::ST_DIV_N : wdc_pkg::ST_FINISH;
      end
      wdc_pkg::ST_DIV_N: begin
        if (div_done) state_d = wdc_pkg::ST_DIV_WDAY;
      end
      wdc_pkg::ST_DIV_WDAY: begin
        if (div_done) state_d = wdc_pkg::ST_TALLY;
      end
      wdc_pkg::ST_TALLY:  state_d = wdc_pkg::ST_FINISH;
      wdc_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) state_d = wdc_pkg::ST_IDLE;
      end
      default: state_d = wdc_pkg::ST_IDLE;
    endcase
  end

  // divider loads and handshake outputs
  always_comb begin
    div_ld     = 1'b0;
    div_ld_num = '0;
    div_ld_dvs = wdc_pkg::DVS_CENTURY;
    unique case (state_q)
      wdc_pkg::ST_IDLE: begin
        div_ld     = s_hs;
        div_ld_num = DIV_W'(s_item.start_year);
      end
      wdc_pkg::ST_DIV_YS: begin
        div_ld     = div_done;
        div_ld_num = DIV_W'(item_q.end_year);
      end
      wdc_pkg::ST_DIFF: begin
        div_ld     = ser_e_q > ser_s_q;
        div_ld_num = DIV_W'(ser_e_q - ser_s_q);
        div_ld_dvs = wdc_pkg::DVS_WEEK;
      end
      wdc_pkg::ST_DIV_N: begin
        div_ld     = div_done;
        div_ld_num = DIV_W'(ser_s_q);
        div_ld_dvs = wdc_pkg::DVS_WEEK;
      end
      default: begin
        div_ld = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = state_q == wdc_pkg::ST_IDLE;
  assign out_load      = (state_q == wdc_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wdc_pkg::ST_IDLE;
      div_half_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_ld) begin
        div_half_q <= 1'b0;
      end else if ((state_q == wdc_pkg::ST_DIV_YS) || (state_q == wdc_pkg::ST_DIV_YE) ||
                   (state_q == wdc_pkg::ST_DIV_N)  || (state_q == wdc_pkg::ST_DIV_WDAY)) begin
        div_half_q <= !div_half_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider registers, quotient in the cycle after the operand
  always_ff @(posedge clk_i) begin
    if (div_ld) begin
      div_num_q <= div_ld_num;
      div_dvs_q <= div_ld_dvs;
    end
    div_quo_q <= div_quo_d;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      item_q <= s_item;
    end
    unique case (state_q)
      wdc_pkg::ST_DIV_YS: begin
        if (div_done) begin
          cs_q <= div_quo_q[wdc_pkg::CENT_W-1:0];
          rs_q <= div_rem;
        end
      end
      wdc_pkg::ST_DIV_YE: begin
        if (div_done) begin
          ce_q <= div_quo_q[wdc_pkg::CENT_W-1:0];
          re_q <= div_rem;
        end
      end
      wdc_pkg::ST_CHECK: begin
        base_q    <= base_val;
        res_cnt_q <= '0;
        res_inv_q <= 1'b1;
      end
      wdc_pkg::ST_SUM_S:  ser_s_q <= term_val;
      wdc_pkg::ST_BASE_E: base_q  <= base_val;
      wdc_pkg::ST_SUM_E:  ser_e_q <= term_val;
      wdc_pkg::ST_DIFF: begin
        res_cnt_q <= wdc_pkg::COUNT_W'(item_q.include_end);
        res_inv_q <= 1'b0;
      end
      wdc_pkg::ST_DIV_N: begin
        if (div_done) begin
          quo_q <= div_quo_q[SER_W-1:0];
          rmd_q <= div_rem[2:0];
        end
      end
      wdc_pkg::ST_DIV_WDAY: begin
        if (div_done) wday_q <= wday_nxt;
      end
      wdc_pkg::ST_TALLY: begin
        res_cnt_q <= tally_cnt;
        res_inv_q <= 1'b0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_cnt_q <= res_cnt_q;
      out_inv_q <= res_inv_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = wdc_pkg::OUT_DATA_W'(out_cnt_q);
  assign m_axis_tuser[0] = out_inv_q;

`ifndef SYNTHESIS
  // one item at a time: an accept drops ready on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after an accepted beat");

  // a flagged date always carries a zero count
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[wdc_pkg::COUNT_W-1:0] == '0)
    else $error("invalid date beat with nonzero count");

  // the span division only runs on a positive span
  a_span_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wdc_pkg::ST_DIV_N |-> ser_e_q > ser_s_q)
    else $error("span division entered with end not after start");
`endif

endmodule
